[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the vector ALU lane.
// Uses clk and rst of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/fvalu_pkg.sv]
// Action codes, float constants and float helper functions for the vector ALU lane.
// No dependencies.
package fvalu_pkg;

  localparam int ACT_W = 5;

  localparam logic [ACT_W-1:0] ACT_SEL    = 5'd0;
  localparam logic [ACT_W-1:0] ACT_FADD   = 5'd1;
  localparam logic [ACT_W-1:0] ACT_FSUB   = 5'd2;
  localparam logic [ACT_W-1:0] ACT_FSUBR  = 5'd3;
  localparam logic [ACT_W-1:0] ACT_FMUL   = 5'd4;
  localparam logic [ACT_W-1:0] ACT_IMUL24 = 5'd5;
  localparam logic [ACT_W-1:0] ACT_FMIN   = 5'd6;
  localparam logic [ACT_W-1:0] ACT_FMAX   = 5'd7;
  localparam logic [ACT_W-1:0] ACT_IMAX   = 5'd8;
  localparam logic [ACT_W-1:0] ACT_IMIN   = 5'd9;
  localparam logic [ACT_W-1:0] ACT_UMIN   = 5'd10;
  localparam logic [ACT_W-1:0] ACT_UMAX   = 5'd11;
  localparam logic [ACT_W-1:0] ACT_LSHR   = 5'd12;
  localparam logic [ACT_W-1:0] ACT_ASHR   = 5'd13;
  localparam logic [ACT_W-1:0] ACT_LSHL   = 5'd14;
  localparam logic [ACT_W-1:0] ACT_LSHLR  = 5'd15;
  localparam logic [ACT_W-1:0] ACT_AND    = 5'd16;
  localparam logic [ACT_W-1:0] ACT_OR     = 5'd17;
  localparam logic [ACT_W-1:0] ACT_XOR    = 5'd18;
  localparam logic [ACT_W-1:0] ACT_FMAC   = 5'd19;
  localparam logic [ACT_W-1:0] ACT_FMADK  = 5'd20;
  localparam logic [ACT_W-1:0] ACT_ADDC   = 5'd21;
  localparam logic [ACT_W-1:0] ACT_ADD    = 5'd22;
  localparam logic [ACT_W-1:0] ACT_ADDCU  = 5'd23;
  localparam logic [ACT_W-1:0] ACT_SUBB   = 5'd24;
  localparam logic [ACT_W-1:0] ACT_SUBBU  = 5'd25;
  localparam logic [ACT_W-1:0] ACT_SUBRB  = 5'd26;
  localparam logic [ACT_W-1:0] ACT_SUBRBU = 5'd27;

  localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT   = 32'h00400000;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;

  typedef logic [31:0] word_t;

  function automatic logic f_isnan(word_t x);
    return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_isinf(word_t x);
    return (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic f_iszero(word_t x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic f_lt(word_t a, word_t b);
    logic r;
    if (f_isnan(a) || f_isnan(b) || (f_iszero(a) && f_iszero(b))) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  function automatic logic [5:0] clz48(logic [47:0] p);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] clz27(logic [26:0] p);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (p[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // Rounds a 27-bit significand (hidden bit at 26, then guard, round, sticky)
  // to nearest even and packs it; an exponent of 1 with bit 26 clear is subnormal.
  function automatic word_t round_pack(logic s, logic [9:0] e, logic [26:0] m);
    logic        inc;
    logic [24:0] r;
    logic [9:0]  ee;
    logic [7:0]  ef;
    word_t       res;
    inc = m[2] & ((|m[1:0]) | m[3]);
    r = {1'b0, m[26:3]} + 25'(inc);
    ee = e;
    if (r[24]) begin
      r = r >> 1;
      ee = ee + 10'd1;
    end
    ef = r[23] ? ee[7:0] : 8'd0;
    if (ee >= 10'd255) begin
      res = {s, EXP_MAX, 23'd0};
    end else begin
      res = {s, ef, r[22:0]};
    end
    return res;
  endfunction

endpackage

[rtl/fvalu_int.sv]
// Integer, logic, shift, select and float compare actions, one register stage.
// Depends on fvalu_pkg.
module fvalu_int (
  input  logic                      clk,
  input  logic [fvalu_pkg::ACT_W-1:0] action,
  input  logic [31:0]               a,
  input  logic [31:0]               b,
  input  logic                      cond,
  output logic [31:0]               res,
  output logic                      cy,
  output logic                      cv
);
  import fvalu_pkg::*;

  logic [31:0] res_next;
  logic        cy_next;
  logic        cv_next;
  logic [32:0] add_w;
  logic [32:0] sub_ab;
  logic [32:0] sub_ba;

  always_comb begin
    add_w  = {1'b0, a} + {1'b0, b};
    sub_ab = {1'b0, a} - {1'b0, b};
    sub_ba = {1'b0, b} - {1'b0, a};
    res_next = 32'd0;
    cy_next  = 1'b0;
    cv_next  = 1'b0;
    case (action)
      ACT_SEL:   res_next = cond ? b : a;
      ACT_FMIN:  res_next = f_lt(a, b) ? a : b;
      ACT_FMAX:  res_next = f_lt(b, a) ? a : b;
      ACT_IMAX:  res_next = ($signed(a) > $signed(b)) ? a : b;
      ACT_IMIN:  res_next = ($signed(a) < $signed(b)) ? a : b;
      ACT_UMIN:  res_next = (a < b) ? a : b;
      ACT_UMAX:  res_next = (a > b) ? a : b;
      ACT_LSHR:  res_next = b >> a[4:0];
      ACT_ASHR:  res_next = 32'($signed(b) >>> a[4:0]);
      ACT_LSHL:  res_next = a << b[4:0];
      ACT_LSHLR: res_next = b << a[4:0];
      ACT_AND:   res_next = a & b;
      ACT_OR:    res_next = a | b;
      ACT_XOR:   res_next = a ^ b;
      ACT_ADD:   res_next = add_w[31:0];
      ACT_ADDC, ACT_ADDCU: begin
        res_next = add_w[31:0];
        cy_next  = add_w[32];
        cv_next  = 1'b1;
      end
      ACT_SUBB, ACT_SUBBU: begin
        res_next = sub_ab[31:0];
        cy_next  = sub_ab[32];
        cv_next  = 1'b1;
      end
      ACT_SUBRB, ACT_SUBRBU: begin
        res_next = sub_ba[31:0];
        cy_next  = sub_ba[32];
        cv_next  = 1'b1;
      end
      default: res_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    cy  <= cy_next;
    cv  <= cv_next;
  end

endmodule

[rtl/fvalu_mul.sv]
// Three-stage multiplier: shared 25x25 signed array, leading-zero count,
// then normalize and round to a single-precision product. Depends on fvalu_pkg.
module fvalu_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        int_mode,
  output logic [31:0] prod,
  output logic [31:0] raw
);
  import fvalu_pkg::*;

  logic [7:0]         ea, eb;
  logic [24:0]        opa, opb;
  logic signed [49:0] full;
  logic [31:0]        spec_val;
  logic               spec;

  logic [47:0] s1_p;
  logic [31:0] s1_raw;
  logic [8:0]  s1_esum;
  logic        s1_sign;
  logic        s1_spec;
  logic [31:0] s1_spec_val;

  logic [47:0]        s2_p;
  logic [31:0]        s2_raw;
  logic [5:0]         s2_lz;
  logic signed [10:0] s2_e;
  logic               s2_sign;
  logic               s2_spec;
  logic [31:0]        s2_spec_val;

  logic [47:0]        ps, q;
  logic signed [10:0] shv;
  logic [5:0]         sh;
  logic               lost;
  logic [9:0]         ee;
  logic [31:0]        prod_next;

  always_comb begin
    ea  = a[30:23];
    eb  = b[30:23];
    opa = int_mode ? {a[23], a[23:0]} : {1'b0, |ea, a[22:0]};
    opb = int_mode ? {b[23], b[23:0]} : {1'b0, |eb, b[22:0]};
    full = $signed(opa) * $signed(opb);
    spec = 1'b1;
    if (f_isnan(a)) begin
      spec_val = a | QUIET_BIT;
    end else if (f_isnan(b)) begin
      spec_val = b | QUIET_BIT;
    end else if (f_isinf(a) || f_isinf(b)) begin
      spec_val = (f_iszero(a) || f_iszero(b)) ? DEFAULT_NAN : {a[31] ^ b[31], EXP_MAX, 23'd0};
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    s1_p        <= full[47:0];
    s1_raw      <= full[31:0];
    s1_esum     <= {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
    s1_sign     <= a[31] ^ b[31];
    s1_spec     <= spec;
    s1_spec_val <= spec_val;
  end

  always_ff @(posedge clk) begin
    s2_p        <= s1_p;
    s2_raw      <= s1_raw;
    s2_lz       <= clz48(s1_p);
    s2_e        <= $signed({2'b00, s1_esum}) - 11'sd126 - $signed({5'd0, clz48(s1_p)});
    s2_sign     <= s1_sign;
    s2_spec     <= s1_spec;
    s2_spec_val <= s1_spec_val;
  end

  always_comb begin
    ps  = s2_p << s2_lz;
    shv = 11'sd1 - s2_e;
    if (s2_e < 11'sd1) begin
      sh   = (shv > 11'sd63) ? 6'd63 : shv[5:0];
      q    = ps >> sh;
      lost = |(ps & ~({48{1'b1}} << sh));
      ee   = 10'd1;
    end else begin
      sh   = 6'd0;
      q    = ps;
      lost = 1'b0;
      ee   = s2_e[9:0];
    end
    if (s2_spec) begin
      prod_next = s2_spec_val;
    end else if (s2_p == 48'd0) begin
      prod_next = {s2_sign, 31'd0};
    end else begin
      prod_next = round_pack(s2_sign, ee, {q[47:22], (|q[21:0]) | lost});
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    raw  <= s2_raw;
  end

endmodule

[rtl/fvalu_add.sv]
// Three-stage single-precision adder: align and add, leading-zero count,
// then normalize and round. Depends on fvalu_pkg.
module fvalu_add (
  input  logic        clk,
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic        neg,
  output logic [31:0] sum
);
  import fvalu_pkg::*;

  logic [31:0] yn, big, sml, spec_val;
  logic        spec;
  logic [7:0]  el, es, d;
  logic [23:0] ml, ms;
  logic [26:0] ms27, al;
  logic [27:0] raw_sum;

  logic [27:0] s1_sum;
  logic [7:0]  s1_e;
  logic        s1_sign, s1_zs, s1_spec;
  logic [31:0] s1_spec_val;

  logic [27:0] s2_sum;
  logic [7:0]  s2_e;
  logic [4:0]  s2_lz;
  logic        s2_sign, s2_zs, s2_spec;
  logic [31:0] s2_spec_val;

  logic [7:0]  sh;
  logic [26:0] m27;
  logic [9:0]  ee;
  logic [31:0] sum_next;

  always_comb begin
    yn   = {y[31] ^ neg, y[30:0]};
    spec = 1'b1;
    if (f_isnan(x)) begin
      spec_val = x | QUIET_BIT;
    end else if (f_isnan(y)) begin
      spec_val = y | QUIET_BIT;
    end else if (f_isinf(x) && f_isinf(yn) && (x[31] != yn[31])) begin
      spec_val = DEFAULT_NAN;
    end else if (f_isinf(x)) begin
      spec_val = x;
    end else if (f_isinf(yn)) begin
      spec_val = yn;
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
    if (x[30:0] < yn[30:0]) begin
      big = yn;
      sml = x;
    end else begin
      big = x;
      sml = yn;
    end
    el   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ml   = {|big[30:23], big[22:0]};
    ms   = {|sml[30:23], sml[22:0]};
    d    = el - es;
    ms27 = {ms, 3'b000};
    if (d >= 8'd27) begin
      al = {26'd0, |ms};
    end else begin
      al = (ms27 >> d) | {26'd0, |(ms27 & ~({27{1'b1}} << d))};
    end
    if (big[31] ^ sml[31]) begin
      raw_sum = {1'b0, ml, 3'b000} - {1'b0, al};
    end else begin
      raw_sum = {1'b0, ml, 3'b000} + {1'b0, al};
    end
  end

  always_ff @(posedge clk) begin
    s1_sum      <= raw_sum;
    s1_e        <= el;
    s1_sign     <= big[31];
    s1_zs       <= big[31] & sml[31];
    s1_spec     <= spec;
    s1_spec_val <= spec_val;
  end

  always_ff @(posedge clk) begin
    s2_sum      <= s1_sum;
    s2_e        <= s1_e;
    s2_lz       <= clz27(s1_sum[26:0]);
    s2_sign     <= s1_sign;
    s2_zs       <= s1_zs;
    s2_spec     <= s1_spec;
    s2_spec_val <= s1_spec_val;
  end

  always_comb begin
    sh = 8'd0;
    if (s2_sum[27]) begin
      m27 = {s2_sum[27:2], |s2_sum[1:0]};
      ee  = {2'b00, s2_e} + 10'd1;
    end else begin
      sh  = ({3'd0, s2_lz} < (s2_e - 8'd1)) ? {3'd0, s2_lz} : (s2_e - 8'd1);
      m27 = s2_sum[26:0] << sh;
      ee  = {2'b00, s2_e} - {2'b00, sh};
    end
    if (s2_spec) begin
      sum_next = s2_spec_val;
    end else if (s2_sum == 28'd0) begin
      sum_next = {s2_zs, 31'd0};
    end else begin
      sum_next = round_pack(s2_sign, ee, m27);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

[rtl/gpu_vector_two_operand_alu_top.sv]
// Top level of one vector ALU lane: integer unit, float multiplier and float adder.
// Depends on fvalu_pkg, fvalu_int, fvalu_mul, fvalu_add and assert_macros.svh.
//
// Channel  Handshake           Payload
// input    start / busy        action, operand_a, operand_b, accumulator, literal_k,
//                              lane_condition
// result   done (one cycle)    result_value, carry_bit, carry_valid
//
// One item can be transferred in every cycle while busy is low; the depth of the
// pipeline is set by the multiply then add chain.
// busy is high only during reset. Reset clears the valid bits of all stages.
// Results cannot be stalled; the pipeline always advances.
`include "assert_macros.svh"
module gpu_vector_two_operand_alu_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fvalu_pkg::ACT_W-1:0] action,
  input  logic [31:0]                 operand_a,
  input  logic [31:0]                 operand_b,
  input  logic [31:0]                 accumulator,
  input  logic [31:0]                 literal_k,
  input  logic                        lane_condition,
  output logic                        done,
  output logic [31:0]                 result_value,
  output logic                        carry_bit,
  output logic                        carry_valid
);
  import fvalu_pkg::*;

  logic [6:1]       vld;
  logic [ACT_W-1:0] act_p [1:6];
  logic [31:0]      a_p   [1:3];
  logic [31:0]      b_p   [1:3];
  logic [31:0]      d_p   [1:3];
  logic [31:0]      ir_p  [2:6];
  logic             icy_p [2:6];
  logic             icv_p [2:6];
  logic [31:0]      prod_p [4:6];
  logic [31:0]      raw_p  [4:6];

  logic [31:0] int_res, prod, raw, add_x, add_y, add_sum, res_next;
  logic        int_cy, int_cv, add_neg;

  assign busy = rst;

  fvalu_int u_int (
    .clk    (clk),
    .action (action),
    .a      (operand_a),
    .b      (operand_b),
    .cond   (lane_condition),
    .res    (int_res),
    .cy     (int_cy),
    .cv     (int_cv)
  );

  fvalu_mul u_mul (
    .clk      (clk),
    .a        (operand_a),
    .b        ((action == ACT_FMADK) ? literal_k : operand_b),
    .int_mode (action == ACT_IMUL24),
    .prod     (prod),
    .raw      (raw)
  );

  always_comb begin
    add_neg = (act_p[3] == ACT_FSUB) || (act_p[3] == ACT_FSUBR);
    if (act_p[3] inside {ACT_FMAC, ACT_FMADK}) begin
      add_x = prod;
      add_y = (act_p[3] == ACT_FMAC) ? d_p[3] : b_p[3];
    end else if (act_p[3] == ACT_FSUBR) begin
      add_x = b_p[3];
      add_y = a_p[3];
    end else begin
      add_x = a_p[3];
      add_y = b_p[3];
    end
  end

  fvalu_add u_add (
    .clk (clk),
    .x   (add_x),
    .y   (add_y),
    .neg (add_neg),
    .sum (add_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:1], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    act_p[1] <= action;
    a_p[1]   <= operand_a;
    b_p[1]   <= operand_b;
    d_p[1]   <= accumulator;
    for (int i = 2; i <= 3; i++) begin
      a_p[i] <= a_p[i-1];
      b_p[i] <= b_p[i-1];
      d_p[i] <= d_p[i-1];
    end
    for (int i = 2; i <= 6; i++) begin
      act_p[i] <= act_p[i-1];
    end
    ir_p[2]  <= int_res;
    icy_p[2] <= int_cy;
    icv_p[2] <= int_cv;
    for (int i = 3; i <= 6; i++) begin
      ir_p[i]  <= ir_p[i-1];
      icy_p[i] <= icy_p[i-1];
      icv_p[i] <= icv_p[i-1];
    end
    prod_p[4] <= prod;
    raw_p[4]  <= raw;
    for (int i = 5; i <= 6; i++) begin
      prod_p[i] <= prod_p[i-1];
      raw_p[i]  <= raw_p[i-1];
    end
  end

  always_comb begin
    if (act_p[6] inside {ACT_FADD, ACT_FSUB, ACT_FSUBR, ACT_FMAC, ACT_FMADK}) begin
      res_next = add_sum;
    end else if (act_p[6] == ACT_FMUL) begin
      res_next = prod_p[6];
    end else if (act_p[6] == ACT_IMUL24) begin
      res_next = raw_p[6];
    end else begin
      res_next = ir_p[6];
    end
  end

  always_ff @(posedge clk) begin
    result_value <= res_next;
    if (rst) begin
      done        <= 1'b0;
      carry_bit   <= 1'b0;
      carry_valid <= 1'b0;
    end else begin
      done        <= vld[6];
      carry_bit   <= vld[6] & icy_p[6];
      carry_valid <= vld[6] & icv_p[6];
    end
  end

  `ASSERT_HOLDS(a_latency, done |-> $past(start && !busy, 7), "result without a transfer")
  `ASSERT_NEVER(a_carry_flag, carry_bit && !carry_valid, "carry bit without valid flag")
  `ASSERT_NEVER(a_carry_idle, carry_valid && !done, "carry flag outside a result")

endmodule

[test/gpu_vector_two_operand_alu_top_test.sv]
// Self-checking testbench for gpu_vector_two_operand_alu_top, one vector ALU lane.
// Depends on fvalu_pkg for action codes and on the RTL of the lane; it carries its own float math.
module gpu_vector_two_operand_alu_top_test;
  import fvalu_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 5'd28;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 5'd31;
  localparam logic [31:0] SIGN_MASK = 32'h80000000;
  localparam logic [31:0] POS_INF = 32'h7F800000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PAUSE_AT = 1000;
  localparam int RANDOM_ITEMS = 1730;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    logic [31:0] k;
    logic cond;
  } lane_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic carry;
    logic carry_ok;
  } lane_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ACT_W-1:0] action = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic [31:0] accumulator = '0;
  logic [31:0] literal_k = '0;
  logic lane_condition = 1'b0;
  logic done;
  logic [31:0] result_value;
  logic carry_bit;
  logic carry_valid;

  lane_op_t pending_ops[$];
  lane_res_t expected_res[$];
  lane_op_t cur_op;
  int errors = 0;
  int sent = 0;
  int gap_left = 0;
  int cycles = 0;
  bit burst = 1'b0;

  gpu_vector_two_operand_alu_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .operand_a(operand_a), .operand_b(operand_b), .accumulator(accumulator),
    .literal_k(literal_k), .lane_condition(lane_condition), .done(done),
    .result_value(result_value), .carry_bit(carry_bit), .carry_valid(carry_valid)
  );

  always #6 clk = ~clk;

  function automatic bit is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  function automatic bit is_inf(logic [31:0] x);
    return x[30:0] == POS_INF[30:0];
  endfunction

  function automatic bit is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic void unpack_f(logic [31:0] x, output logic [23:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = {1'b0, x[22:0]};
      e = -149;
    end else begin
      m = {1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Rounds mag * 2^e to single precision, nearest even.
  function automatic logic [31:0] round_f(logic s, logic [319:0] mag, int e);
    int p;
    int lsb;
    int sh;
    logic [319:0] q;
    logic [319:0] low;
    logic half;
    logic sticky;
    logic [31:0] bits;
    if (mag == '0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 320; i++) if (mag[i]) p = i;
    lsb = p + e - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - e;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else begin
      q = mag >> sh;
      half = mag[sh-1];
      low = (320'd1 << (sh - 1)) - 320'd1;
      sticky = |(mag & low);
      if (half && (sticky || q[0])) q = q + 320'd1;
    end
    if (q[24]) begin
      q = q >> 1;
      lsb = lsb + 1;
    end
    if (lsb + 150 >= 255) return {s, 8'hFF, 23'd0};
    bits = (32'(lsb + 149) << 23) + {8'd0, q[23:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] float_add(logic [31:0] a, logic [31:0] b);
    logic [23:0] ma;
    logic [23:0] mb;
    int ea;
    int eb;
    int emin;
    logic [319:0] wa;
    logic [319:0] wb;
    logic [319:0] m;
    logic s;
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : DEFAULT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    unpack_f(a, ma, ea);
    unpack_f(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    wa = 320'(ma) << (ea - emin);
    wb = 320'(mb) << (eb - emin);
    if (a[31] == b[31]) begin
      m = wa + wb;
      s = a[31];
    end else if (wa > wb) begin
      m = wa - wb;
      s = a[31];
    end else if (wb > wa) begin
      m = wb - wa;
      s = b[31];
    end else begin
      m = '0;
      s = 1'b0;
    end
    return round_f(s, m, emin);
  endfunction

  function automatic logic [31:0] float_sub(logic [31:0] a, logic [31:0] b);
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    return float_add(a, b ^ SIGN_MASK);
  endfunction

  function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
    logic [23:0] ma;
    logic [23:0] mb;
    int ea;
    int eb;
    logic s;
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
    s = a[31] ^ b[31];
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    unpack_f(a, ma, ea);
    unpack_f(b, mb, eb);
    return round_f(s, 320'(ma) * 320'(mb), ea + eb);
  endfunction

  function automatic bit float_less(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) return 1'b0;
    ka = a[31] ? ~a : (a | SIGN_MASK);
    kb = b[31] ? ~b : (b | SIGN_MASK);
    return ka < kb;
  endfunction

  function automatic lane_res_t lane_predict(lane_op_t op);
    lane_res_t r;
    logic signed [47:0] prod;
    r = '0;
    case (op.act)
      ACT_SEL: r.value = op.cond ? op.b : op.a;
      ACT_FADD: r.value = float_add(op.a, op.b);
      ACT_FSUB: r.value = float_sub(op.a, op.b);
      ACT_FSUBR: r.value = float_sub(op.b, op.a);
      ACT_FMUL: r.value = float_mul(op.a, op.b);
      ACT_IMUL24: begin
        prod = 48'(signed'(op.a[23:0])) * 48'(signed'(op.b[23:0]));
        r.value = prod[31:0];
      end
      ACT_FMIN: r.value = float_less(op.a, op.b) ? op.a : op.b;
      ACT_FMAX: r.value = float_less(op.b, op.a) ? op.a : op.b;
      ACT_IMAX: r.value = ($signed(op.a) > $signed(op.b)) ? op.a : op.b;
      ACT_IMIN: r.value = ($signed(op.a) < $signed(op.b)) ? op.a : op.b;
      ACT_UMIN: r.value = (op.a < op.b) ? op.a : op.b;
      ACT_UMAX: r.value = (op.a > op.b) ? op.a : op.b;
      ACT_LSHR: r.value = op.b >> op.a[4:0];
      ACT_ASHR: r.value = 32'($signed(op.b) >>> op.a[4:0]);
      ACT_LSHL: r.value = op.a << op.b[4:0];
      ACT_LSHLR: r.value = op.b << op.a[4:0];
      ACT_AND: r.value = op.a & op.b;
      ACT_OR: r.value = op.a | op.b;
      ACT_XOR: r.value = op.a ^ op.b;
      ACT_FMAC: r.value = float_add(float_mul(op.a, op.b), op.d);
      ACT_FMADK: r.value = float_add(float_mul(op.a, op.k), op.b);
      ACT_ADD: r.value = op.a + op.b;
      ACT_ADDC, ACT_ADDCU: begin
        {r.carry, r.value} = {1'b0, op.a} + {1'b0, op.b};
        r.carry_ok = 1'b1;
      end
      ACT_SUBB, ACT_SUBBU: begin
        r.value = op.a - op.b;
        r.carry = op.b > op.a;
        r.carry_ok = 1'b1;
      end
      ACT_SUBRB, ACT_SUBRBU: begin
        r.value = op.b - op.a;
        r.carry = op.a > op.b;
        r.carry_ok = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[14];
    specials = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h7F800001, 32'h00000001, 32'h007FFFFF, 32'h00800000, 32'h3F800000,
                 32'hFFFFFFFF, 32'h7F7FFFFF, 32'hBF800000, 32'h0000001F};
    case ($urandom_range(0, 9))
      0, 1: return specials[$urandom_range(0, 13)];
      2, 3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [ACT_W-1:0] act, logic [31:0] a, logic [31:0] b,
                          logic [31:0] d, logic [31:0] k, logic cond);
    pending_ops.push_back('{act, a, b, d, k, cond});
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_res.push_back(lane_predict(cur_op));
        sent++;
        if (sent % 150 == 0) burst = ~burst;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (sent == PAUSE_AT && expected_res.size() > 0) begin
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        action <= cur_op.act;
        operand_a <= cur_op.a;
        operand_b <= cur_op.b;
        accumulator <= cur_op.d;
        literal_k <= cur_op.k;
        lane_condition <= cur_op.cond;
        start <= 1'b1;
        gap_left = burst ? 0 : $urandom_range(0, 7);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lane_res_t want;
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", result_value, 32'd0);
      end else begin
        want = expected_res.pop_front();
        if (result_value !== want.value) report_mismatch("result_value", result_value, want.value);
        if (carry_bit !== want.carry) report_mismatch("carry_bit", 32'(carry_bit), 32'(want.carry));
        if (carry_valid !== want.carry_ok)
          report_mismatch("carry_valid", 32'(carry_valid), 32'(want.carry_ok));
      end
    end
  end

  initial begin
    queue_op(ACT_SEL, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1);
    queue_op(ACT_SEL, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    queue_op(ACT_FADD, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FADD, 32'h7F800000, 32'hFF800000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FSUB, 32'h00800000, 32'h007FFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FSUBR, 32'h3F800000, 32'h3F800000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMUL, 32'h7F800000, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMUL, 32'h00000001, 32'h3F000000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_IMUL24, 32'hFF800000, 32'h00FFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMIN, 32'h7FC00000, 32'h3F800000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMAX, 32'h3F800000, 32'h7F800001, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMIN, 32'h80000000, 32'h00000000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_IMAX, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_IMIN, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_UMIN, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_UMAX, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_LSHR, 32'hFFFFFFFF, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_ASHR, 32'h0000003F, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_LSHL, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_LSHLR, 32'h00000020, 32'h00000001, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_FMAC, 32'h3F800001, 32'h3F800001, 32'hBF800000, 32'h0, 1'b0);
    queue_op(ACT_FMADK, 32'h40000000, 32'hC0800000, 32'h0, 32'h40000000, 1'b0);
    queue_op(ACT_ADDC, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_SUBB, 32'h00000000, 32'h00000001, 32'h0, 32'h0, 1'b0);
    queue_op(ACT_SPARE_HI, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_op(5'($urandom_range(0, 9) == 0 ? $urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)
                                            : $urandom_range(ACT_SEL, ACT_SUBRBU)),
               pick_operand(), pick_operand(), pick_operand(), pick_operand(),
               1'($urandom_range(0, 1)));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() > 0 || start || expected_res.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
